// ----- rtl/hpwl_pkg.sv -----
// Shared types and constants for the net half-perimeter wirelength block.
package hpwl_pkg;

    localparam int COORD_BITS   = 20;
    localparam int LEN_BITS     = COORD_BITS + 2;
    localparam int SUM_BITS     = COORD_BITS + 14;
    localparam int CFG_IDX_BITS = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_BOARD_MIN_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOARD_MIN_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOARD_MAX_X = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOARD_MAX_Y = 2'd3;

    // cell orientation codes
    localparam logic [2:0] ORIENT_R0   = 3'd0;
    localparam logic [2:0] ORIENT_R90  = 3'd1;
    localparam logic [2:0] ORIENT_R180 = 3'd2;
    localparam logic [2:0] ORIENT_R270 = 3'd3;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord     center_x;
        t_coord     center_y;
        logic [2:0] orientation;
        t_coord     offset_x;
        t_coord     offset_y;
        logic       pin_present;
        logic       last_in_net;
        logic       last_net;
    } t_pin;

    typedef struct packed {
        logic [LEN_BITS-1:0] net_length;
        logic [SUM_BITS-1:0] total_length;
        logic                design_done;
    } t_result;

    typedef struct packed {
        t_coord min_x;
        t_coord min_y;
        t_coord max_x;
        t_coord max_y;
    } t_box;

endpackage

// ----- rtl/hpwl_pin_xform.sv -----
// Pin position: cell centre plus orientation-rotated offset, saturated.
module hpwl_pin_xform
    import hpwl_pkg::*;
(
    input  t_pin   i_pin,
    output t_coord o_px,
    output t_coord o_py
);

    logic signed [COORD_BITS:0] cx, cy, ox, oy, sx, sy;

    function automatic t_coord sat(input logic signed [COORD_BITS:0] v);
        t_coord r;
        if (v[COORD_BITS] != v[COORD_BITS-1]) begin
            r = v[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                              : {1'b0, {(COORD_BITS-1){1'b1}}};
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

    assign cx = {i_pin.center_x[COORD_BITS-1], i_pin.center_x};
    assign cy = {i_pin.center_y[COORD_BITS-1], i_pin.center_y};
    assign ox = {i_pin.offset_x[COORD_BITS-1], i_pin.offset_x};
    assign oy = {i_pin.offset_y[COORD_BITS-1], i_pin.offset_y};

    always_comb begin
        unique case (i_pin.orientation)
            ORIENT_R0: begin
                sx = cx + ox;
                sy = cy + oy;
            end
            ORIENT_R90: begin
                sx = cx + oy;
                sy = cy - ox;
            end
            ORIENT_R180: begin
                sx = cx - ox;
                sy = cy - oy;
            end
            ORIENT_R270: begin
                sx = cx - oy;
                sy = cy + ox;
            end
            default: begin  // unrotated codes: centre only
                sx = cx;
                sy = cy;
            end
        endcase
    end

    assign o_px = sat(sx);
    assign o_py = sat(sy);

endmodule

// ----- rtl/hpwl_box_track.sv -----
// Net bounding box tracker; hands the finished box of each net downstream.
module hpwl_box_track
    import hpwl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_box   i_board_box,   // inverted start box from the board edges
    input  t_pin   i_pin,
    input  t_coord i_px,
    input  t_coord i_py,
    input  logic   i_fire,        // pin register consumed this cycle
    input  logic   i_take,        // next stage takes a held box
    output logic   o_free,
    output logic   o_fin_vld,
    output t_box   o_fin,
    output logic   o_fin_done
);

    t_box r_box, n_box, cur_box;
    logic r_box_used;
    logic r_fin_vld;
    t_box r_fin;
    logic r_fin_done;

    // untouched box follows the live board registers
    assign cur_box = r_box_used ? r_box : i_board_box;

    always_comb begin
        n_box = cur_box;
        if (i_pin.pin_present) begin
            if (i_px < cur_box.min_x) n_box.min_x = i_px;
            if (i_px > cur_box.max_x) n_box.max_x = i_px;
            if (i_py < cur_box.min_y) n_box.min_y = i_py;
            if (i_py > cur_box.max_y) n_box.max_y = i_py;
        end
    end

    assign o_free = !r_fin_vld || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_used <= 1'b0;
            r_fin_vld  <= 1'b0;
        end else begin
            if (i_fire) begin
                r_box_used <= i_pin.last_in_net ? 1'b0 : (r_box_used | i_pin.pin_present);
            end
            if (i_fire && i_pin.last_in_net) begin
                r_fin_vld <= 1'b1;
            end else if (i_take) begin
                r_fin_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_box <= n_box;
        end
        if (i_fire && i_pin.last_in_net) begin
            r_fin      <= n_box;
            r_fin_done <= i_pin.last_net;
        end
    end

    assign o_fin_vld  = r_fin_vld;
    assign o_fin      = r_fin;
    assign o_fin_done = r_fin_done;

endmodule

// ----- rtl/hpwl_len_stage.sv -----
// Half-perimeter of a finished box, registered.
module hpwl_len_stage
    import hpwl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  t_box                i_box,
    input  logic                i_done,
    input  logic                i_take,
    output logic                o_free,
    output logic                o_vld,
    output logic [LEN_BITS-1:0] o_len,
    output logic                o_done
);

    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS:0]        ax, ay;
    logic [LEN_BITS-1:0]        n_len;
    logic                       load;
    logic                       r_vld;
    logic [LEN_BITS-1:0]        r_len;
    logic                       r_done;

    assign dx = {i_box.max_x[COORD_BITS-1], i_box.max_x}
              - {i_box.min_x[COORD_BITS-1], i_box.min_x};
    assign dy = {i_box.max_y[COORD_BITS-1], i_box.max_y}
              - {i_box.min_y[COORD_BITS-1], i_box.min_y};
    assign ax = dx[COORD_BITS] ? (COORD_BITS+1)'(0) - dx : dx;
    assign ay = dy[COORD_BITS] ? (COORD_BITS+1)'(0) - dy : dy;
    assign n_len = {1'b0, ax} + {1'b0, ay};

    assign o_free = !r_vld || i_take;
    assign load   = i_vld && o_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_len  <= n_len;
            r_done <= i_done;
        end
    end

    assign o_vld  = r_vld;
    assign o_len  = r_len;
    assign o_done = r_done;

endmodule

// ----- rtl/hpwl_sum_stage.sv -----
// Saturating running total and the result output register.
module hpwl_sum_stage
    import hpwl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic [LEN_BITS-1:0] i_len,
    input  logic                i_done,
    input  logic                i_out_stall,
    output logic                o_free,
    output logic                o_valid,
    output t_result             o_result
);

    logic [SUM_BITS:0]   sum_ext;
    logic [SUM_BITS-1:0] n_total;
    logic                load;
    logic [SUM_BITS-1:0] r_sum;
    logic                r_out_vld;
    t_result             r_out;

    assign sum_ext = {1'b0, r_sum} + (SUM_BITS+1)'(i_len);
    assign n_total = sum_ext[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_ext[SUM_BITS-1:0];

    assign o_free = !r_out_vld || !i_out_stall;
    assign load   = i_vld && o_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (load) begin
                r_sum <= i_done ? '0 : n_total;
            end
            if (load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.net_length   <= i_len;
            r_out.total_length <= n_total;
            r_out.design_done  <= i_done;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

// ----- rtl/net_hpwl_accumulator.sv -----
// Top level: half-perimeter wirelength per net with a saturating running total.
//
//  channel  direction  handshake             payload
//  -------  ---------  --------------------  ------------------------------
//  in       sink       i_in_valid/o_in_stall  i_in_pin (t_pin), one pin
//  out      source     o_out_valid/i_out_stall o_out_result (t_result)
//  cfg      sink       i_cfg_we               i_cfg_idx, i_cfg_data
//
// One pin per cycle sustained while no net-ending pin waits on a full box stage.
// A net result leaves through pin reg -> box reg -> length reg -> output reg after
// its last pin transfers in; the box min/max update loop sets the pin rate.
// Reset (sync, active low) empties all stages, zeroes the board registers and
// the running total. A stalled output only blocks pins that end a net once the
// stages behind it are full; pins inside a net keep flowing.
module net_hpwl_accumulator
    import hpwl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_pin                    i_in_pin,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_result                 o_out_result,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  t_coord                  i_cfg_data
);

    // board edges
    t_coord r_board_min_x, r_board_min_y, r_board_max_x, r_board_max_y;
    t_box   board_box;

    // pin register
    logic   r_in_vld;
    t_pin   r_in;
    logic   in_xfer;
    logic   pin_fire;

    t_coord px, py;

    logic   fin_free, fin_vld, fin_done;
    t_box   fin_box;
    logic   len_free, len_vld, len_done;
    logic [LEN_BITS-1:0] len_val;
    logic   out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_min_x <= '0;
            r_board_min_y <= '0;
            r_board_max_x <= '0;
            r_board_max_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BOARD_MIN_X: r_board_min_x <= i_cfg_data;
                REG_BOARD_MIN_Y: r_board_min_y <= i_cfg_data;
                REG_BOARD_MAX_X: r_board_max_x <= i_cfg_data;
                REG_BOARD_MAX_Y: r_board_max_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // box starts inverted: min at the far edge, max at the near edge
    assign board_box.min_x = r_board_max_x;
    assign board_box.min_y = r_board_max_y;
    assign board_box.max_x = r_board_min_x;
    assign board_box.max_y = r_board_min_y;

    // a net-ending pin needs room for its finished box
    assign pin_fire   = r_in_vld && (!r_in.last_in_net || fin_free);
    assign o_in_stall = r_in_vld && !pin_fire;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (pin_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_pin;
        end
    end

    hpwl_pin_xform u_xform (
        .i_pin (r_in),
        .o_px  (px),
        .o_py  (py)
    );

    hpwl_box_track u_box (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_board_box (board_box),
        .i_pin       (r_in),
        .i_px        (px),
        .i_py        (py),
        .i_fire      (pin_fire),
        .i_take      (len_free),
        .o_free      (fin_free),
        .o_fin_vld   (fin_vld),
        .o_fin       (fin_box),
        .o_fin_done  (fin_done)
    );

    hpwl_len_stage u_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (fin_vld),
        .i_box   (fin_box),
        .i_done  (fin_done),
        .i_take  (out_free),
        .o_free  (len_free),
        .o_vld   (len_vld),
        .o_len   (len_val),
        .o_done  (len_done)
    );

    hpwl_sum_stage u_sum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (len_vld),
        .i_len       (len_val),
        .i_done      (len_done),
        .i_out_stall (i_out_stall),
        .o_free      (out_free),
        .o_valid     (o_out_valid),
        .o_result    (o_out_result)
    );

    // total includes this net, or sits saturated above it
    a_total_covers_net: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_result.total_length >= SUM_BITS'(o_out_result.net_length)))
        else $error("total below net length");

    // two spans of at most 2^(COORD_BITS)-1 each
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_result.net_length <= LEN_BITS'(2 * ((1 << COORD_BITS) - 1))))
        else $error("net length out of range");

    // a held net end with a full box stage must back-pressure the input
    a_net_end_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_in.last_in_net && fin_vld && !len_free) |-> o_in_stall)
        else $error("net end not stalled");

    // box stage never drops a finished box while the next stage is full
    a_box_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_vld && !len_free) |=> fin_vld)
        else $error("finished box lost");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the net half-perimeter wirelength accumulator.
module tb;
    import hpwl_pkg::*;

    localparam t_coord              COORD_MAX        = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam t_coord              COORD_MIN        = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [SUM_BITS-1:0] SUM_MAX          = '1;
    // first orientation code that leaves the pin offset out
    localparam logic [2:0]          ORIENT_NO_OFFSET = 3'd4;
    localparam int                  IDLE_LIMIT       = 4000;  // cycles with no transfer at all
    localparam int                  HOLDOFF_CYCLES   = 400;
    localparam int                  DRAIN_CYCLES     = 8;     // settle time after the last result is back
    localparam int                  PRINT_LIMIT      = 40;
    localparam int                  FULL_NETS        = 20;    // largest possible net lengths

    // DUT ports; every input starts at a known value
    logic                    i_clk;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_stall;
    t_pin                    i_in_pin    = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    t_result                 o_out_result;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx   = REG_BOARD_MIN_X;
    t_coord                  i_cfg_data  = '0;

    // Predictor state: board edges, the open net box and the running total.
    // board.min_* are the left/bottom edges, board.max_* the right/top edges.
    t_box                board;
    t_box                net_box;
    logic [SUM_BITS-1:0] run_total;
    logic                box_touched;   // open net has taken a present pin

    t_pin    pin_q[$];      // pins waiting for the driver
    t_result length_q[$];   // predicted net results, oldest first
    t_result head;

    // run bookkeeping
    int fail_count   = 0;
    int pins_in      = 0;
    int nets_checked = 0;
    int design_ends  = 0;
    int sat_totals   = 0;
    int cfg_writes   = 0;
    int idle_cycles  = 0;

    // idling controls, set by the sequence below
    bit tx_gaps      = 1'b0;
    bit rx_gaps      = 1'b0;
    bit holdoff_req  = 1'b0;
    int tx_wait      = 0;
    int rx_wait      = 0;
    int holdoff_left = 0;

    net_hpwl_accumulator i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_pin     (i_in_pin),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_result (o_out_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A fresh box is inverted: min at the far board edge, max at the near one.
    function automatic void load_net_box();
        net_box.min_x = board.max_x;
        net_box.min_y = board.max_y;
        net_box.max_x = board.min_x;
        net_box.max_y = board.min_y;
    endfunction

    function automatic t_coord clamp_coord(logic signed [COORD_BITS:0] v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic logic [COORD_BITS:0] span(t_coord a, t_coord b);
        logic signed [COORD_BITS:0] d;
        d = a - b;
        return (d < 0) ? -d : d;
    endfunction

    function automatic void board_write(logic [CFG_IDX_BITS-1:0] idx, t_coord v);
        case (idx)
            REG_BOARD_MIN_X: board.min_x = v;
            REG_BOARD_MIN_Y: board.min_y = v;
            REG_BOARD_MAX_X: board.max_x = v;
            REG_BOARD_MAX_Y: board.max_y = v;
            default: ;
        endcase
        // an untouched box tracks the board, so the write lands on the next net
        if (!box_touched) load_net_box();
    endfunction

    // Folds one accepted pin into the box; a net end queues the expected result.
    function automatic void hpwl_predict(t_pin p);
        t_coord                     cx, cy, ox, oy, sx, sy;
        logic signed [COORD_BITS:0] px, py;
        logic [LEN_BITS-1:0]        len;
        logic [SUM_BITS:0]          sum;
        t_result                    r;
        cx = p.center_x;
        cy = p.center_y;
        ox = p.offset_x;
        oy = p.offset_y;
        if (!box_touched) load_net_box();
        if (p.pin_present) begin
            case (p.orientation)
                ORIENT_R0:   begin px = cx + ox; py = cy + oy; end
                ORIENT_R90:  begin px = cx + oy; py = cy - ox; end
                ORIENT_R180: begin px = cx - ox; py = cy - oy; end
                ORIENT_R270: begin px = cx - oy; py = cy + ox; end
                default:     begin px = cx;      py = cy;      end
            endcase
            sx = clamp_coord(px);
            sy = clamp_coord(py);
            if (sx < net_box.min_x) net_box.min_x = sx;
            if (sx > net_box.max_x) net_box.max_x = sx;
            if (sy < net_box.min_y) net_box.min_y = sy;
            if (sy > net_box.max_y) net_box.max_y = sy;
            box_touched = 1'b1;
        end
        if (p.last_in_net) begin
            len = span(net_box.max_x, net_box.min_x) + span(net_box.max_y, net_box.min_y);
            sum = run_total + len;
            run_total = (sum > SUM_MAX) ? SUM_MAX : sum[SUM_BITS-1:0];
            r.net_length   = len;
            r.total_length = run_total;
            r.design_done  = p.last_net;
            length_q = {length_q, r};
            if (p.last_net) run_total = '0;
            box_touched = 1'b0;
            load_net_box();
        end
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // mostly no idle, some short runs, now and then a long one
    function automatic int idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_coord rand_coord();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0) return COORD_MAX;
        if (r == 1) return COORD_MIN;
        if (r < 5) return t_coord'($urandom);
        return t_coord'(int'($urandom_range(0, 8000)) - 4000);
    endfunction

    function automatic t_coord rand_offset();
        case ($urandom_range(0, 7))
            0:       return t_coord'($urandom);
            1:       return ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
            default: return t_coord'(int'($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    task automatic report_fail(string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic queue_pin(t_coord cx, t_coord cy, logic [2:0] orient, t_coord ox,
                             t_coord oy, bit present, bit net_end, bit design_end);
        t_pin p;
        p.center_x    = cx;
        p.center_y    = cy;
        p.orientation = orient;
        p.offset_x    = ox;
        p.offset_y    = oy;
        p.pin_present = present;
        p.last_in_net = net_end;
        p.last_net    = design_end;
        pin_q = {pin_q, p};
    endtask

    // Nets of random size with random content; last_net also shows up as noise
    // on pins inside a net.
    task automatic push_random_nets(int n_pins);
        int   left, net_len, k;
        t_pin p;
        left = n_pins;
        while (left > 0) begin
            net_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 25) : $urandom_range(1, 6);
            if (net_len > left) net_len = left;
            for (k = 0; k < net_len; k++) begin
                p.center_x    = rand_coord();
                p.center_y    = rand_coord();
                p.offset_x    = rand_offset();
                p.offset_y    = rand_offset();
                p.orientation = ($urandom_range(0, 9) < 8) ?
                                3'($urandom_range(ORIENT_R0, ORIENT_R270)) :
                                3'(ORIENT_NO_OFFSET + $urandom_range(0, 3));
                p.pin_present = ($urandom_range(0, 7) != 0);
                p.last_in_net = (k == net_len - 1);
                p.last_net    = p.last_in_net ? ($urandom_range(0, 5) == 0) :
                                                ($urandom_range(0, 15) == 0);
                pin_q = {pin_q, p};
            end
            left -= net_len;
        end
    endtask

    // Register write; the predictor takes it at once since no pin is in flight.
    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, t_coord v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        board_write(idx, v);
        cfg_writes++;
    endtask

    task automatic board_config(t_coord min_x, t_coord min_y, t_coord max_x, t_coord max_y);
        cfg_write(REG_BOARD_MIN_X, min_x);
        cfg_write(REG_BOARD_MIN_Y, min_y);
        cfg_write(REG_BOARD_MAX_X, max_x);
        cfg_write(REG_BOARD_MAX_Y, max_y);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sender idles until every queued pin has transferred and every net result
    // is back, then lets the pipeline settle before anything else happens.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pin_q.size() != 0 || i_in_valid || length_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(int n_pins, bit gaps_in, bit gaps_out);
        tx_gaps = gaps_in;
        rx_gaps = gaps_out;
        push_random_nets(n_pins);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Pin driver: one payload held until it transfers, random gaps between
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                hpwl_predict(i_in_pin);
                pins_in++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    i_in_valid <= 1'b0;
                end else if (pin_q.size() != 0) begin
                    i_in_pin   <= pin_q.pop_front();
                    i_in_valid <= 1'b1;
                    tx_wait = tx_gaps ? idle_len() : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stall runs, plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (holdoff_req) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_req  = 1'b0;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (rx_wait == 0 && rx_gaps) rx_wait = idle_len();
            if (rx_wait > 0) begin
                rx_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each result transfer against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (length_q.size() == 0) begin
                report_fail($sformatf("unexpected result len=%0d total=%0d done=%0b",
                                      o_out_result.net_length, o_out_result.total_length,
                                      o_out_result.design_done));
            end else begin
                head = length_q.pop_front();
                nets_checked++;
                if (head.design_done) design_ends++;
                if (head.total_length == SUM_MAX) sat_totals++;
                if (o_out_result.net_length !== head.net_length)
                    report_fail($sformatf("net %0d: net_length %0d, predicted %0d",
                                          nets_checked, o_out_result.net_length,
                                          head.net_length));
                if (o_out_result.total_length !== head.total_length)
                    report_fail($sformatf("net %0d: total_length %0d, predicted %0d",
                                          nets_checked, o_out_result.total_length,
                                          head.total_length));
                if (o_out_result.design_done !== head.design_done)
                    report_fail($sformatf("net %0d: design_done %0b, predicted %0b",
                                          nets_checked, o_out_result.design_done,
                                          head.design_done));
            end
        end
    end

    // Watchdog: any transfer or register write restarts the count.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, length_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int k;
        board       = '0;
        run_total   = '0;
        box_touched = 1'b0;
        load_net_box();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // board still at reset: empty net measures zero, then a lone pin
        queue_pin(0, 0, ORIENT_R0, 0, 0, 1'b0, 1'b1, 1'b0);
        queue_pin(-5, 7, ORIENT_R90, 2, 3, 1'b1, 1'b1, 1'b0);
        wait_drained();

        // directed part on a small board
        board_config(-1000, -600, 1000, 600);
        // net with no present pin: inverted box gives board width plus height
        queue_pin(0, 0, ORIENT_R0, 0, 0, 1'b0, 1'b1, 1'b0);
        // design end flag on a pin that does not end its net is ignored
        queue_pin(10, 20, ORIENT_R0, 3, 4, 1'b1, 1'b0, 1'b1);
        queue_pin(-30, 40, ORIENT_R90, 5, -7, 1'b1, 1'b0, 1'b0);
        queue_pin(100, -50, ORIENT_R180, 6, 9, 1'b1, 1'b0, 1'b0);
        queue_pin(-7, -8, ORIENT_R270, 11, -13, 1'b1, 1'b0, 1'b0);
        // codes that skip the offset; the last one closes the net
        for (k = 0; k < 4; k++)
            queue_pin(t_coord'(-900 + 600 * k), t_coord'(500 - 300 * k),
                      3'(ORIENT_NO_OFFSET + k), 4000, -4000, 1'b1, k == 3, 1'b0);
        // pin positions that clip at the coordinate range, every rotation
        queue_pin(COORD_MAX, COORD_MAX, ORIENT_R0, COORD_MAX, COORD_MAX, 1'b1, 1'b0, 1'b0);
        queue_pin(COORD_MIN, COORD_MIN, ORIENT_R180, COORD_MAX, COORD_MAX, 1'b1, 1'b0, 1'b0);
        queue_pin(COORD_MAX, COORD_MAX, ORIENT_R90, COORD_MIN, COORD_MIN, 1'b1, 1'b0, 1'b0);
        queue_pin(COORD_MIN, COORD_MIN, ORIENT_R270, COORD_MIN, COORD_MIN, 1'b1, 1'b1, 1'b0);
        // absent pin then a single present pin; closes the design, total clears
        queue_pin(0, 0, ORIENT_R0, 0, 0, 1'b0, 1'b0, 1'b0);
        queue_pin(3, -3, ORIENT_R0, 1, 1, 1'b1, 1'b1, 1'b1);
        // design made of one empty net
        queue_pin(0, 0, ORIENT_R0, 0, 0, 1'b0, 1'b1, 1'b1);
        wait_drained();

        // full-range board, idling on both sides
        board_config(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        run_phase(60, 1'b1, 1'b1);

        // inverted, lopsided board with back-to-back transfers
        board_config(5000, COORD_MAX, -5000, COORD_MIN);
        run_phase(50, 1'b0, 1'b0);

        // random boards and idling mixes
        for (k = 0; k < 5; k++) begin
            board_config(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            run_phase(50, $urandom_range(0, 1), $urandom_range(0, 1));
        end

        // long receiver hold-off while pins keep coming; the block must fill up
        // and stall its input, then everything drains before the next write
        board_config(-3000, -3000, 3000, 3000);
        tx_gaps     = 1'b0;
        rx_gaps     = 1'b0;
        holdoff_req = 1'b1;
        push_random_nets(100);
        wait_drained();

        // full-board empty nets back to back: largest net lengths, design end last
        board_config(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        tx_gaps = 1'b0;
        rx_gaps = 1'b1;
        for (k = 0; k < FULL_NETS; k++)
            queue_pin(0, 0, ORIENT_R0, 0, 0, 1'b0, 1'b1, k == FULL_NETS - 1);
        wait_drained();

        // board with both axes inverted to the extremes, total restarted
        board_config(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        run_phase(40, 1'b1, 1'b1);

        $display("run covered %0d pins, %0d net results (%0d design ends, %0d saturated)",
                 pins_in, nets_checked, design_ends, sat_totals);
        $display("%0d register writes, %0d mismatches", cfg_writes, fail_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
